FILE: hw/rtl/otm_pkg.sv
// Shared constants, types and command/status structs for the overcurrent trip block.
package otm_pkg;

	localparam int CAL_SAMPLES = 9;
	localparam int CAL_CNT_W   = $clog2(CAL_SAMPLES + 1);
	localparam int MEDIAN_IDX  = CAL_SAMPLES / 2;

	localparam int ACCUM_COUNT = 32;
	localparam int ACCUM_SHIFT = $clog2(ACCUM_COUNT);
	localparam int AMP_SCALE   = 10;
	localparam int TRIP_STEP   = ACCUM_COUNT * AMP_SCALE;

	localparam int SAMPLE_W    = 15;
	localparam int HOLD_W      = 8;
	localparam int AMPS_W      = 5;
	localparam int LEVEL_W     = 10;
	localparam int TRIP_SUM_W  = SAMPLE_W + 2;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};
	localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = {LEVEL_W{1'b1}};

	localparam logic [AMPS_W-1:0]   THRESHOLD_RST = 5'd3;
	localparam logic [HOLD_W-1:0]   HOLD_RST      = 8'd10;
	localparam logic [SAMPLE_W-1:0] LIMIT_RST     = 15'h5000;

	localparam int IN_DATA_W  = 16;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_USED_W = 3 + HOLD_W + SAMPLE_W + LEVEL_W;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_HOLD      = 2'd1,
		REG_LIMIT     = 2'd2,
		REG_NONE      = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_CAL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic cal;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic cal_fin;
		logic out_busy;
	} status_t;

endpackage

FILE: hw/rtl/otm_ctrl.sv
// Sequencer for the overcurrent trip block: accept, step, calibrate, emit.
module otm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  otm_pkg::status_t status,
	output otm_pkg::cmd_t    cmd
);

	otm_pkg::state_t state_q;
	otm_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= otm_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			otm_pkg::ST_IDLE: begin
				if (in_valid) state_next = otm_pkg::ST_STEP;
			end
			otm_pkg::ST_STEP: begin
				state_next = status.cal_fin ? otm_pkg::ST_CAL : otm_pkg::ST_EMIT;
			end
			otm_pkg::ST_CAL: begin
				state_next = otm_pkg::ST_EMIT;
			end
			otm_pkg::ST_EMIT: begin
				if (!status.out_busy) state_next = otm_pkg::ST_IDLE;
			end
			default: begin
				state_next = otm_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			otm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			otm_pkg::ST_STEP: begin
				cmd.step = 1'b1;
			end
			otm_pkg::ST_CAL: begin
				cmd.cal = 1'b1;
			end
			otm_pkg::ST_EMIT: begin
				cmd.emit = !status.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: hw/rtl/otm_dp.sv
// Datapath: sorted calibration store, offset/trip registers, hold counter, result register.
module otm_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  otm_pkg::cmd_t                     cmd,
	output otm_pkg::status_t                  status,
	input  logic [otm_pkg::SAMPLE_W-1:0]      in_sample,
	input  logic                              in_sample_valid,
	input  logic                              in_tick,
	input  logic [otm_pkg::AMPS_W-1:0]        trip_amps,
	input  logic [otm_pkg::HOLD_W-1:0]        hold_ticks,
	input  logic [otm_pkg::SAMPLE_W-1:0]      offset_limit,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [otm_pkg::OUT_DATA_W-1:0]    out_data
);

	localparam int N = otm_pkg::CAL_SAMPLES;
	localparam logic [otm_pkg::CAL_CNT_W-1:0] CNT_LAST = otm_pkg::CAL_CNT_W'(N - 1);

	// item registers
	logic [otm_pkg::SAMPLE_W-1:0] sample_s1;
	logic                         valid_s1;
	logic                         tick_s1;

	// calibration store, kept sorted ascending over the first cal_cnt_q entries
	logic [otm_pkg::SAMPLE_W-1:0] store_q [N];
	logic [otm_pkg::SAMPLE_W-1:0] store_next [N];
	logic [N-1:0]                 gt;
	logic [otm_pkg::CAL_CNT_W-1:0] cal_cnt_q;

	logic [otm_pkg::SAMPLE_W-1:0] offset_q;
	logic [otm_pkg::SAMPLE_W-1:0] trip_q;
	logic                         active_q;
	logic                         done_q;
	logic [otm_pkg::HOLD_W-1:0]   hold_q;

	logic                         out_valid_q;
	logic [otm_pkg::OUT_DATA_W-1:0] out_data_q;

	logic                         cal_item;
	logic                         trip_hit;
	logic [otm_pkg::HOLD_W-1:0]   hold_dec;
	logic [otm_pkg::SAMPLE_W-1:0] median;
	logic [otm_pkg::TRIP_SUM_W-1:0] trip_sum;
	logic [otm_pkg::SAMPLE_W-1:0] rel;
	logic [otm_pkg::SAMPLE_W-1:0] rel_shift;
	logic [otm_pkg::LEVEL_W-1:0]  level;

	assign cal_item = valid_s1 && !done_q;
	assign trip_hit = valid_s1 && done_q && active_q && (sample_s1 > trip_q);
	assign hold_dec = (tick_s1 && active_q && (hold_q != '0)) ? hold_q - 1'b1 : hold_q;

	assign status.cal_fin  = cal_item && (cal_cnt_q == CNT_LAST);
	assign status.out_busy = out_valid_q && !out_ready;

	// insertion: every filled entry above the new sample moves up one slot
	always_comb begin
		for (int i = 0; i < N; i++) begin
			gt[i] = (otm_pkg::CAL_CNT_W'(i) < cal_cnt_q) && (store_q[i] > sample_s1);
		end
		for (int i = 0; i < N; i++) begin
			store_next[i] = store_q[i];
			if (otm_pkg::CAL_CNT_W'(i) < cal_cnt_q) begin
				if (gt[i]) begin
					store_next[i] = (i > 0 && gt[(i > 0) ? i - 1 : 0]) ?
						store_q[(i > 0) ? i - 1 : 0] : sample_s1;
				end
			end else if (otm_pkg::CAL_CNT_W'(i) == cal_cnt_q) begin
				store_next[i] = (i > 0 && gt[(i > 0) ? i - 1 : 0]) ?
					store_q[(i > 0) ? i - 1 : 0] : sample_s1;
			end
		end
	end

	assign median   = store_q[otm_pkg::MEDIAN_IDX];
	assign trip_sum = otm_pkg::TRIP_SUM_W'(median)
		+ otm_pkg::TRIP_SUM_W'(trip_amps) * otm_pkg::TRIP_SUM_W'(otm_pkg::TRIP_STEP);

	assign rel       = (sample_s1 > offset_q) ? sample_s1 - offset_q : '0;
	assign rel_shift = rel >> otm_pkg::ACCUM_SHIFT;
	always_comb begin
		if (!valid_s1 || !done_q) begin
			level = '0;
		end else if (rel_shift > otm_pkg::SAMPLE_W'(otm_pkg::LEVEL_MAX)) begin
			level = otm_pkg::LEVEL_MAX;
		end else begin
			level = rel_shift[otm_pkg::LEVEL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_s1 <= in_sample;
			valid_s1  <= in_sample_valid;
			tick_s1   <= in_tick;
		end
		if (cmd.step && cal_item) begin
			for (int i = 0; i < N; i++) begin
				store_q[i] <= store_next[i];
			end
		end
		if (cmd.emit) begin
			out_data_q <= {
				(otm_pkg::OUT_DATA_W - otm_pkg::OUT_USED_W)'(0),
				level, offset_q, hold_q, (hold_q != '0), active_q, done_q
			};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_cnt_q   <= '0;
			offset_q    <= '0;
			trip_q      <= '0;
			active_q    <= 1'b0;
			done_q      <= 1'b0;
			hold_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.step) begin
				hold_q <= trip_hit ? hold_ticks : hold_dec;
				if (cal_item) cal_cnt_q <= cal_cnt_q + 1'b1;
			end
			if (cmd.cal) begin
				offset_q <= median;
				active_q <= median < offset_limit;
				trip_q   <= (trip_sum > otm_pkg::TRIP_SUM_W'(otm_pkg::SAMPLE_MAX)) ?
					otm_pkg::SAMPLE_MAX : trip_sum[otm_pkg::SAMPLE_W-1:0];
				done_q   <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_hold_needs_active: assert property (@(posedge clk) disable iff (!arst_n)
		(hold_q != '0) |-> (active_q && done_q))
		else $error("hold counter running while sensor inactive");

	// the count is full only in the calibration step or once that step has set done
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cal_cnt_q <= otm_pkg::CAL_CNT_W'(N)) &&
		(done_q || cmd.cal || cal_cnt_q < otm_pkg::CAL_CNT_W'(N)))
		else $error("calibration count out of range");

	a_trip_above_offset: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (trip_q >= offset_q))
		else $error("trip level below zero offset");

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid_q && !out_ready))
		else $error("result register overwritten before transaction");

	a_cal_only_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cal |-> !done_q)
		else $error("second calibration");

endmodule

FILE: hw/rtl/overcurrent_trip_median_offset.sv
// Top level of the overcurrent trip block with median zero-offset calibration.
// Usage:
//   Input stream s_*: one transaction per step. s_tdata carries the accumulated
//   ADC sample, s_tuser the flags that say what the item holds.
//   Output stream m_*: exactly one result transaction per input transaction,
//   in order.
//   APB port: trip amps at 0x0, hold ticks at 0x4, offset limit at 0x8;
//   write only while no item is in flight.
// Timing:
//   After acceptance an item passes the step and emit states before the next
//   acceptance; the item that completes calibration also passes the cal state,
//   which fixes the median, the active flag and the trip level. The emit state
//   registers the result. The step sequencer handles one item at a time.
//   Calibration samples are insertion-sorted into a 9-entry store as they arrive.
// Reset:
//   arst_n clears the sequencer, calibration state and hold counter, and loads
//   the register defaults (3 A, 10 ticks, limit 0x5000).
// Stall:
//   A result waits in the output register; the next item is still accepted and
//   processed, then held in its emit step until m_tready frees the register.
module overcurrent_trip_median_offset (
	input  logic                              clk,
	input  logic                              arst_n,
	// [14:0] sample, [15] zero
	input  logic [otm_pkg::IN_DATA_W-1:0]     s_tdata,
	// [0] sample_valid, [1] tick
	input  logic [otm_pkg::IN_USER_W-1:0]     s_tuser,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [0] calibrated, [1] sensor_active, [2] cutoff, [10:3] hold_remaining,
	// [25:11] zero_offset, [35:26] current_level, [39:36] zero
	output logic [otm_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [otm_pkg::ADDR_W-1:0]        paddr,
	input  logic [otm_pkg::DATA_W-1:0]        pwdata,
	output logic [otm_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);

	logic [otm_pkg::AMPS_W-1:0]   threshold_q;
	logic [otm_pkg::HOLD_W-1:0]   hold_ticks_q;
	logic [otm_pkg::SAMPLE_W-1:0] limit_q;
	otm_pkg::reg_idx_t            reg_idx;
	logic                         wr_en;

	otm_pkg::cmd_t    cmd;
	otm_pkg::status_t status;

	assign pready  = 1'b1;
	assign reg_idx = otm_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= otm_pkg::THRESHOLD_RST;
			hold_ticks_q <= otm_pkg::HOLD_RST;
			limit_q      <= otm_pkg::LIMIT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				otm_pkg::REG_THRESHOLD: threshold_q  <= pwdata[otm_pkg::AMPS_W-1:0];
				otm_pkg::REG_HOLD:      hold_ticks_q <= pwdata[otm_pkg::HOLD_W-1:0];
				otm_pkg::REG_LIMIT:     limit_q      <= pwdata[otm_pkg::SAMPLE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			otm_pkg::REG_THRESHOLD: prdata = otm_pkg::DATA_W'(threshold_q);
			otm_pkg::REG_HOLD:      prdata = otm_pkg::DATA_W'(hold_ticks_q);
			otm_pkg::REG_LIMIT:     prdata = otm_pkg::DATA_W'(limit_q);
			default:                prdata = '0;
		endcase
	end

	otm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	otm_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.in_sample       (s_tdata[otm_pkg::SAMPLE_W-1:0]),
		.in_sample_valid (s_tuser[0]),
		.in_tick         (s_tuser[1]),
		.trip_amps       (threshold_q),
		.hold_ticks      (hold_ticks_q),
		.offset_limit    (limit_q),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_data        (m_tdata)
	);

endmodule

FILE: tb/overcurrent_trip_median_offset_tb.sv
// Testbench for the overcurrent trip block: predicts each result and compares it field by field.
module overcurrent_trip_median_offset_tb;

	localparam int CYCLE_LIMIT = 300000;
	localparam int LONG_HOLD   = 100;

	typedef struct packed {
		logic                         calibrated;
		logic                         sensor_active;
		logic                         cutoff;
		logic [otm_pkg::HOLD_W-1:0]   hold_remaining;
		logic [otm_pkg::SAMPLE_W-1:0] zero_offset;
		logic [otm_pkg::LEVEL_W-1:0]  current_level;
	} sense_report_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic [otm_pkg::IN_DATA_W-1:0]  s_tdata;
	logic [otm_pkg::IN_USER_W-1:0]  s_tuser;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [otm_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           m_tvalid;
	logic                           m_tready;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [otm_pkg::ADDR_W-1:0]     paddr;
	logic [otm_pkg::DATA_W-1:0]     pwdata;
	logic [otm_pkg::DATA_W-1:0]     prdata;
	logic                           pready;

	// predicted block state and register copies
	logic [otm_pkg::AMPS_W-1:0]   thr_amps;
	logic [otm_pkg::HOLD_W-1:0]   hold_cfg;
	logic [otm_pkg::SAMPLE_W-1:0] limit_cfg;
	logic [otm_pkg::SAMPLE_W-1:0] cal_buf [otm_pkg::CAL_SAMPLES];
	int unsigned                  cal_n;
	logic [otm_pkg::SAMPLE_W-1:0] zero_ofs;
	logic [otm_pkg::SAMPLE_W-1:0] trip_lvl;
	bit                           is_active;
	bit                           is_done;
	logic [otm_pkg::HOLD_W-1:0]   hold_cnt;

	sense_report_t report_q [$];
	int            err_cnt = 0;
	int            cycle_cnt = 0;
	bit            burst_mode = 1'b0;
	bit            long_hold_req = 1'b0;

	overcurrent_trip_median_offset dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// one step of the sensor: tick first, then calibration or trip check
	function automatic sense_report_t advance_sensor(logic [otm_pkg::SAMPLE_W-1:0] smp,
		bit vld, bit tck);
		sense_report_t                r;
		logic [otm_pkg::SAMPLE_W-1:0] sorted [$];
		int                           margin;
		r = '0;
		if (tck && is_active && hold_cnt != 0)
			hold_cnt--;
		if (vld) begin
			if (!is_done) begin
				if (cal_n < otm_pkg::CAL_SAMPLES)
					cal_buf[cal_n] = smp;
				cal_n++;
				if (cal_n >= otm_pkg::CAL_SAMPLES) begin
					foreach (cal_buf[i])
						sorted.push_back(cal_buf[i]);
					sorted.sort();
					zero_ofs = sorted[otm_pkg::MEDIAN_IDX];
					is_active = zero_ofs < limit_cfg;
					margin = int'(zero_ofs) + otm_pkg::TRIP_STEP * int'(thr_amps);
					trip_lvl = (margin > int'(otm_pkg::SAMPLE_MAX)) ?
						otm_pkg::SAMPLE_MAX : otm_pkg::SAMPLE_W'(margin);
					is_done = 1'b1;
					cal_n = otm_pkg::CAL_SAMPLES;
				end
			end else if (is_active && smp > trip_lvl) begin
				hold_cnt = hold_cfg;
			end
			// a 15-bit difference shifted by 5 never exceeds the level ceiling
			if (is_done && smp > zero_ofs)
				r.current_level = otm_pkg::LEVEL_W'((smp - zero_ofs) >> otm_pkg::ACCUM_SHIFT);
		end
		r.calibrated     = is_done;
		r.sensor_active  = is_active;
		r.cutoff         = hold_cnt != 0;
		r.hold_remaining = hold_cnt;
		r.zero_offset    = zero_ofs;
		return r;
	endfunction

	task automatic cmp_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			err_cnt++;
		end
	endtask

	always @(posedge clk) begin
		sense_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (report_q.size() == 0) begin
				$error("result transaction with no report pending: m_tdata %h", m_tdata);
				err_cnt++;
			end else begin
				want = report_q.pop_front();
				cmp_field("calibrated", want.calibrated, m_tdata[0]);
				cmp_field("sensor_active", want.sensor_active, m_tdata[1]);
				cmp_field("cutoff", want.cutoff, m_tdata[2]);
				cmp_field("hold_remaining", want.hold_remaining, m_tdata[10:3]);
				cmp_field("zero_offset", want.zero_offset, m_tdata[25:11]);
				cmp_field("current_level", want.current_level, m_tdata[35:26]);
			end
		end
	end

	// result receiver with random stalls and the occasional long hold-off
	initial begin
		int gap;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				gap = LONG_HOLD;
				long_hold_req = 1'b0;
			end else begin
				gap = burst_mode ? 0 : $urandom_range(0, 14);
			end
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	task automatic push_item(input logic [otm_pkg::SAMPLE_W-1:0] smp, input bit vld,
		input bit tck);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= {1'b0, smp};
		s_tuser  <= {tck, vld};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		report_q.push_back(advance_sensor(smp, vld, tck));
	endtask

	task automatic drain_reports();
		s_tvalid <= 1'b0;
		while (report_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input otm_pkg::reg_idx_t idx,
		input logic [otm_pkg::DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			otm_pkg::REG_THRESHOLD: thr_amps  = val[otm_pkg::AMPS_W-1:0];
			otm_pkg::REG_HOLD:      hold_cfg  = val[otm_pkg::HOLD_W-1:0];
			otm_pkg::REG_LIMIT:     limit_cfg = val[otm_pkg::SAMPLE_W-1:0];
			default: ;
		endcase
	endtask

	function automatic logic [otm_pkg::SAMPLE_W-1:0] pick_sample();
		int v;
		case ($urandom_range(0, 4))
			0: v = int'(trip_lvl) + $urandom_range(0, 64) - 32;
			1: v = int'(zero_ofs) + $urandom_range(0, 64) - 48;
			2: v = $urandom_range(0, 1) ? int'(otm_pkg::SAMPLE_MAX) : 0;
			default: v = $urandom_range(0, int'(otm_pkg::SAMPLE_MAX));
		endcase
		if (v < 0)
			v = 0;
		if (v > int'(otm_pkg::SAMPLE_MAX))
			v = int'(otm_pkg::SAMPLE_MAX);
		return otm_pkg::SAMPLE_W'(v);
	endfunction

	// sweep every register through its extremes, then settle on values for calibration
	task automatic test_config_sweep();
		write_reg(otm_pkg::REG_THRESHOLD, '0);
		write_reg(otm_pkg::REG_HOLD, '0);
		write_reg(otm_pkg::REG_LIMIT, '0);
		write_reg(otm_pkg::REG_NONE, '1);
		write_reg(otm_pkg::REG_THRESHOLD, '1);
		write_reg(otm_pkg::REG_HOLD, '1);
		write_reg(otm_pkg::REG_LIMIT, '1);
		write_reg(otm_pkg::REG_THRESHOLD, $urandom_range(0, 31));
		write_reg(otm_pkg::REG_HOLD, $urandom_range(1, 255));
		// calibration samples keep the median at or below 2000, so the sensor ends up active
		write_reg(otm_pkg::REG_LIMIT, $urandom_range(2001, 32767));
	endtask

	task automatic test_calibration();
		logic [otm_pkg::SAMPLE_W-1:0] cal_vals [otm_pkg::CAL_SAMPLES];
		foreach (cal_vals[i])
			cal_vals[i] = $urandom_range(200, 2000);
		cal_vals[1] = '0;
		cal_vals[4] = otm_pkg::SAMPLE_MAX;
		// ignored items and ticks before the sensor is calibrated
		push_item(otm_pkg::SAMPLE_MAX, 1'b0, 1'b1);
		push_item('0, 1'b0, 1'b0);
		foreach (cal_vals[i]) begin
			push_item(cal_vals[i], 1'b1, (i % 3) == 0);
			if (i == 5)
				push_item(otm_pkg::SAMPLE_MAX, 1'b0, 1'b1);
		end
		drain_reports();
	endtask

	task automatic test_trip_hold();
		write_reg(otm_pkg::REG_HOLD, '1);
		push_item(trip_lvl, 1'b1, 1'b0);
		push_item(trip_lvl + 1'b1, 1'b1, 1'b0);
		push_item('0, 1'b0, 1'b1);
		// trip and tick together leave the full hold count
		push_item(trip_lvl + 1'b1, 1'b1, 1'b1);
		push_item('0, 1'b1, 1'b0);
		push_item(otm_pkg::SAMPLE_MAX, 1'b1, 1'b0);
		push_item(otm_pkg::SAMPLE_MAX, 1'b0, 1'b0);
		drain_reports();
		// threshold and limit are fixed once calibrated
		write_reg(otm_pkg::REG_HOLD, 32'd1);
		write_reg(otm_pkg::REG_THRESHOLD, '1);
		write_reg(otm_pkg::REG_LIMIT, '0);
		push_item(trip_lvl + 1'b1, 1'b1, 1'b0);
		push_item('0, 1'b0, 1'b1);
		push_item('0, 1'b0, 1'b1);
		drain_reports();
		write_reg(otm_pkg::REG_HOLD, '0);
		push_item(trip_lvl + 1'b1, 1'b1, 1'b1);
		drain_reports();
	endtask

	task automatic test_random_traffic(input int n_items, input bit no_idle);
		burst_mode = no_idle;
		for (int i = 0; i < n_items; i++) begin
			push_item(pick_sample(), $urandom_range(0, 3) != 0, $urandom_range(0, 2) == 0);
			if ($urandom_range(0, 39) == 0)
				drain_reports();
		end
		drain_reports();
		burst_mode = 1'b0;
	endtask

	task automatic retune_registers();
		case ($urandom_range(0, 3))
			0: write_reg(otm_pkg::REG_HOLD, '0);
			1: write_reg(otm_pkg::REG_HOLD, '1);
			2: write_reg(otm_pkg::REG_HOLD, 32'd1);
			default: write_reg(otm_pkg::REG_HOLD, $urandom());
		endcase
		write_reg(otm_pkg::REG_THRESHOLD, $urandom());
		write_reg(otm_pkg::REG_LIMIT, $urandom());
		write_reg(otm_pkg::REG_NONE, $urandom());
	endtask

	// receiver holds off while items keep coming, so the input side backs up
	task automatic test_backpressure();
		long_hold_req = 1'b1;
		burst_mode = 1'b1;
		for (int i = 0; i < 24; i++)
			push_item(pick_sample(), 1'b1, $urandom_range(0, 1));
		drain_reports();
		burst_mode = 1'b0;
	endtask

	initial begin
		thr_amps  = otm_pkg::THRESHOLD_RST;
		hold_cfg  = otm_pkg::HOLD_RST;
		limit_cfg = otm_pkg::LIMIT_RST;
		cal_n     = 0;
		zero_ofs  = '0;
		trip_lvl  = '0;
		is_active = 1'b0;
		is_done   = 1'b0;
		hold_cnt  = '0;
		arst_n   <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		s_tvalid <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_config_sweep();
		test_calibration();
		test_trip_hold();
		for (int p = 0; p < 6; p++) begin
			retune_registers();
			test_random_traffic(70, p == 2);
			if (p == 3)
				test_backpressure();
		end

		drain_reports();
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/otm_pkg.sv
hw/rtl/otm_ctrl.sv
hw/rtl/otm_dp.sv
hw/rtl/overcurrent_trip_median_offset.sv
tb/overcurrent_trip_median_offset_tb.sv
